// ----- rtl/cmdws_pkg.sv -----
// cmdws_pkg: types, character codes and the per-byte parse function
// of the command line word splitter
// depends on nothing; used by cmdws_step and command_line_word_splitter_top
package cmdws_pkg;

    // parser modes
    typedef enum logic [2:0] {
        MODE_BETWEEN = 3'd0,
        MODE_PLAIN   = 3'd1,
        MODE_SINGLE  = 3'd2,
        MODE_DOUBLE  = 3'd3,
        MODE_ESCAPE  = 3'd4,
        MODE_ERROR   = 3'd5
    } mode_t;

    // result kinds
    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_EOW  = 2'd1,
        KIND_DONE = 2'd2,
        KIND_ERR  = 2'd3
    } kind_t;

    // error codes
    localparam logic [1:0] ERR_BADCHAR = 2'd0;
    localparam logic [1:0] ERR_NOSEP   = 2'd1;
    localparam logic [1:0] ERR_BADESC  = 2'd2;
    localparam logic [1:0] ERR_UNCLOSE = 2'd3;

    // character codes
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_T  = 8'h74;

    localparam logic [15:0] TALLY_MAX = 16'hFFFF;

    // parser state carried from byte to byte
    typedef struct packed {
        mode_t       mode;
        logic        sep;
        logic [15:0] tally;
        logic [1:0]  err;
    } state_t;

    localparam state_t ST_RESET = '{mode: MODE_BETWEEN, sep: 1'b1,
                                    tally: 16'd0, err: ERR_BADCHAR};

    // one result item
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  value;
        logic [15:0] words;
        logic        last;
    } result_t;

    // outcome of parsing one byte
    typedef struct packed {
        state_t  st;
        logic    v;
        result_t r;
    } feed_t;

    function automatic logic [15:0] sat_inc(input logic [15:0] t);
        return (t == TALLY_MAX) ? t : t + 16'd1;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB);
    endfunction

    function automatic logic bad_quoted(input logic [7:0] c);
        return (c == CH_NUL) || (c == CH_LF) || (c == CH_CR);
    endfunction

    function automatic logic bad_plain(input logic [7:0] c);
        return bad_quoted(c) || (c == CH_BSLASH) || (c == CH_DQUOTE) ||
               (c == CH_SQUOTE);
    endfunction

    // parse one byte in the given state; at most one result
    function automatic feed_t feed(input state_t s, input logic [7:0] c);
        feed_t f;
        f.st      = s;
        f.v       = 1'b0;
        f.r.kind  = KIND_BYTE;
        f.r.value = c;
        f.r.words = s.tally;
        f.r.last  = 1'b0;
        unique case (s.mode)
            MODE_BETWEEN:
            begin
                if (is_blank(c))
                begin
                    f.st.sep = 1'b1;
                end
                else if (!s.sep)
                begin
                    f.st.mode = MODE_ERROR;
                    f.st.err  = ERR_NOSEP;
                    f.v       = 1'b1;
                    f.r.kind  = KIND_ERR;
                    f.r.value = {6'd0, ERR_NOSEP};
                end
                else
                begin
                    f.st.sep = 1'b0;
                    if (c == CH_SQUOTE)
                    begin
                        f.st.mode = MODE_SINGLE;
                    end
                    else if (c == CH_DQUOTE)
                    begin
                        f.st.mode = MODE_DOUBLE;
                    end
                    else if (bad_plain(c))
                    begin
                        f.st.mode = MODE_ERROR;
                        f.st.err  = ERR_BADCHAR;
                        f.v       = 1'b1;
                        f.r.kind  = KIND_ERR;
                        f.r.value = {6'd0, ERR_BADCHAR};
                    end
                    else
                    begin
                        f.st.mode = MODE_PLAIN;
                        f.v       = 1'b1;
                    end
                end
            end
            MODE_PLAIN:
            begin
                if (is_blank(c))
                begin
                    f.st.tally = sat_inc(s.tally);
                    f.st.mode  = MODE_BETWEEN;
                    f.st.sep   = 1'b1;
                    f.v        = 1'b1;
                    f.r.kind   = KIND_EOW;
                    f.r.value  = 8'd0;
                    f.r.words  = sat_inc(s.tally);
                end
                else if (bad_plain(c))
                begin
                    f.st.mode = MODE_ERROR;
                    f.st.err  = ERR_BADCHAR;
                    f.v       = 1'b1;
                    f.r.kind  = KIND_ERR;
                    f.r.value = {6'd0, ERR_BADCHAR};
                end
                else
                begin
                    f.v = 1'b1;
                end
            end
            MODE_SINGLE, MODE_DOUBLE:
            begin
                if ((s.mode == MODE_SINGLE && c == CH_SQUOTE) ||
                    (s.mode == MODE_DOUBLE && c == CH_DQUOTE))
                begin
                    f.st.tally = sat_inc(s.tally);
                    f.st.mode  = MODE_BETWEEN;
                    f.st.sep   = 1'b0;
                    f.v        = 1'b1;
                    f.r.kind   = KIND_EOW;
                    f.r.value  = 8'd0;
                    f.r.words  = sat_inc(s.tally);
                end
                else if (bad_quoted(c))
                begin
                    f.st.mode = MODE_ERROR;
                    f.st.err  = ERR_BADCHAR;
                    f.v       = 1'b1;
                    f.r.kind  = KIND_ERR;
                    f.r.value = {6'd0, ERR_BADCHAR};
                end
                else if (s.mode == MODE_DOUBLE && c == CH_BSLASH)
                begin
                    f.st.mode = MODE_ESCAPE;
                end
                else
                begin
                    f.v = 1'b1;
                end
            end
            MODE_ESCAPE:
            begin
                if (c == CH_LOW_N || c == CH_LOW_R || c == CH_LOW_T ||
                    c == CH_BSLASH || c == CH_DQUOTE)
                begin
                    f.st.mode = MODE_DOUBLE;
                    f.v       = 1'b1;
                    if (c == CH_LOW_N)
                    begin
                        f.r.value = CH_LF;
                    end
                    else if (c == CH_LOW_R)
                    begin
                        f.r.value = CH_CR;
                    end
                    else if (c == CH_LOW_T)
                    begin
                        f.r.value = CH_TAB;
                    end
                end
                else
                begin
                    f.st.mode = MODE_ERROR;
                    f.st.err  = ERR_BADESC;
                    f.v       = 1'b1;
                    f.r.kind  = KIND_ERR;
                    f.r.value = {6'd0, ERR_BADESC};
                end
            end
            default:
            begin
                // error mode stays silent
                f.v = 1'b0;
            end
        endcase
        return f;
    endfunction

endpackage

// ----- rtl/cmdws_in_if.sv -----
// cmdws_in_if: input byte channel of the word splitter
// valid/ready handshake carrying one command line byte and its last flag
interface cmdws_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       line_last;

    modport source (output valid, output char_in, output line_last, input ready);
    modport sink   (input valid, input char_in, input line_last, output ready);
endinterface

// ----- rtl/cmdws_out_if.sv -----
// cmdws_out_if: result channel of the word splitter
// valid/ready handshake carrying one result item
interface cmdws_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  value;
    logic [15:0] words_seen;
    logic        result_last;

    modport source (output valid, output kind, output value, output words_seen,
                    output result_last, input ready);
    modport sink   (input valid, input kind, input value, input words_seen,
                    input result_last, output ready);
endinterface

// ----- rtl/cmdws_step.sv -----
// cmdws_step: combinational parse of one input byte, giving up to three
// results in order and the next parser state; uses cmdws_pkg
module cmdws_step (
    input  cmdws_pkg::state_t         st,
    input  logic                      held_cr,
    input  logic [7:0]                char_in,
    input  logic                      line_last,
    output cmdws_pkg::state_t         st_next,
    output logic                      held_cr_next,
    output cmdws_pkg::result_t [2:0]  res,
    output logic [1:0]                res_count
);

    logic                      drop_lf;
    logic                      do_cr;
    logic                      do_c;
    cmdws_pkg::feed_t          f_cr;
    cmdws_pkg::state_t         st_mid;
    cmdws_pkg::feed_t          f_c;
    cmdws_pkg::state_t         st_end;
    logic                      err_now;
    cmdws_pkg::result_t [3:0]  cand;
    logic [3:0]                cand_v;
    logic [15:0]               tally_inc;
    logic [2:0]                n;

    // which bytes get parsed: a held cr first, then the current byte
    assign drop_lf = line_last && (char_in == cmdws_pkg::CH_LF);
    assign do_cr   = held_cr && !drop_lf;
    assign do_c    = (char_in != cmdws_pkg::CH_CR) && !drop_lf;
    assign held_cr_next = !line_last && (char_in == cmdws_pkg::CH_CR);

    // two chained parse steps
    always_comb
    begin
        f_cr   = cmdws_pkg::feed(st, cmdws_pkg::CH_CR);
        st_mid = do_cr ? f_cr.st : st;
        f_c    = cmdws_pkg::feed(st_mid, char_in);
        st_end = do_c ? f_c.st : st_mid;
    end

    assign err_now   = (do_cr && f_cr.v && f_cr.r.kind == cmdws_pkg::KIND_ERR) ||
                       (do_c && f_c.v && f_c.r.kind == cmdws_pkg::KIND_ERR);
    assign tally_inc = cmdws_pkg::sat_inc(st_end.tally);

    // candidate results, including the end of line results
    always_comb
    begin
        cand[0]  = f_cr.r;
        cand[1]  = f_c.r;
        cand_v[0] = do_cr && f_cr.v;
        cand_v[1] = do_c && f_c.v;
        cand[2]  = '{kind: cmdws_pkg::KIND_DONE, value: 8'd0,
                     words: st_end.tally, last: 1'b1};
        cand[3]  = '{kind: cmdws_pkg::KIND_DONE, value: 8'd0,
                     words: tally_inc, last: 1'b1};
        cand_v[2] = 1'b0;
        cand_v[3] = 1'b0;
        if (line_last)
        begin
            unique case (st_end.mode)
                cmdws_pkg::MODE_PLAIN:
                begin
                    cand[2].kind  = cmdws_pkg::KIND_EOW;
                    cand[2].words = tally_inc;
                    cand[2].last  = 1'b0;
                    cand_v[2]     = 1'b1;
                    cand_v[3]     = 1'b1;
                end
                cmdws_pkg::MODE_SINGLE, cmdws_pkg::MODE_DOUBLE:
                begin
                    cand[2].kind  = cmdws_pkg::KIND_ERR;
                    cand[2].value = {6'd0, cmdws_pkg::ERR_UNCLOSE};
                    cand_v[2]     = 1'b1;
                end
                cmdws_pkg::MODE_ESCAPE:
                begin
                    cand[2].kind  = cmdws_pkg::KIND_ERR;
                    cand[2].value = {6'd0, cmdws_pkg::ERR_BADESC};
                    cand_v[2]     = 1'b1;
                end
                cmdws_pkg::MODE_ERROR:
                begin
                    if (err_now)
                    begin
                        // the error of this byte closes the line
                        if (cand_v[1])
                        begin
                            cand[1].last = 1'b1;
                        end
                        else
                        begin
                            cand[0].last = 1'b1;
                        end
                    end
                    else
                    begin
                        cand[2].kind  = cmdws_pkg::KIND_ERR;
                        cand[2].value = {6'd0, st_end.err};
                        cand_v[2]     = 1'b1;
                    end
                end
                default:
                begin
                    // between words: line done only
                    cand_v[2] = 1'b1;
                end
            endcase
        end
    end

    // pack valid candidates in order
    always_comb
    begin
        res = '0;
        n   = 3'd0;
        for (int i = 0; i < 4; i++)
        begin
            if (cand_v[i] && n < 3'd3)
            begin
                res[n[1:0]] = cand[i];
                n = n + 3'd1;
            end
        end
    end

    assign res_count = n[1:0];
    assign st_next   = line_last ? cmdws_pkg::ST_RESET : st_end;

endmodule

// ----- rtl/command_line_word_splitter_top.sv -----
// command_line_word_splitter_top: splits a command line into quoted words
// depends on cmdws_pkg, cmdws_in_if, cmdws_out_if and cmdws_step
//
//   channel   dir   payload                                    transfer
//   in_ch     in    char_in[7:0], line_last                    valid && ready
//   out_ch    out   kind[1:0], value[7:0], words_seen[15:0],   valid && ready
//                   result_last
//
// a byte is parsed in the cycle it is taken; its zero to three results sit
// in a result register and leave one per cycle while out_ch is ready, from
// the next cycle on; a new byte is taken every cycle while each byte gives at
// most one result and out_ch is ready; more results stall the input as they drain
// rst_n clears parser state and empties the result register; no clearing pass
// a stalled output holds its result and keeps the input stalled until the last
// waiting result leaves
module command_line_word_splitter_top (
    input  logic              clk,
    input  logic              rst_n,
    cmdws_in_if.sink          in_ch,
    cmdws_out_if.source       out_ch
);

    cmdws_pkg::state_t         st_reg;
    cmdws_pkg::state_t         st_next;
    logic                      held_cr_reg;
    logic                      held_cr_next;
    cmdws_pkg::result_t [2:0]  res_reg;
    cmdws_pkg::result_t [2:0]  res_next;
    logic [1:0]                cnt_reg;
    logic [1:0]                cnt_next;
    logic [1:0]                idx_reg;
    logic [1:0]                rd_idx;
    cmdws_pkg::result_t        res_out;
    logic                      in_xfer;
    logic                      out_xfer;

    // combinational parse of the incoming byte
    cmdws_step u_step (
        .st           (st_reg),
        .held_cr      (held_cr_reg),
        .char_in      (in_ch.char_in),
        .line_last    (in_ch.line_last),
        .st_next      (st_next),
        .held_cr_next (held_cr_next),
        .res          (res_next),
        .res_count    (cnt_next)
    );

    // handshakes
    assign out_ch.valid = (idx_reg != cnt_reg);
    assign out_xfer     = out_ch.valid && out_ch.ready;
    assign in_ch.ready  = (idx_reg == cnt_reg) ||
                          (out_ch.ready && (cnt_reg - idx_reg == 2'd1));
    assign in_xfer      = in_ch.valid && in_ch.ready;

    // result read port
    assign rd_idx  = (idx_reg == 2'd3) ? 2'd2 : idx_reg;
    assign res_out = res_reg[rd_idx];
    assign out_ch.kind        = res_out.kind;
    assign out_ch.value       = res_out.value;
    assign out_ch.words_seen  = res_out.words;
    assign out_ch.result_last = res_out.last;

    // parser state and drain control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg      <= cmdws_pkg::ST_RESET;
            held_cr_reg <= 1'b0;
            cnt_reg     <= 2'd0;
            idx_reg     <= 2'd0;
        end
        else if (in_xfer)
        begin
            st_reg      <= st_next;
            held_cr_reg <= held_cr_next;
            cnt_reg     <= cnt_next;
            idx_reg     <= 2'd0;
        end
        else if (out_xfer)
        begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            res_reg <= res_next;
        end
    end

    // drain pointer never passes the fill count
    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= cnt_reg)
        else $error("result index beyond fill count");

    // a line's last byte returns the parser to its reset state
    a_line_reset: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && in_ch.line_last |=>
            st_reg == cmdws_pkg::ST_RESET && !held_cr_reg)
        else $error("parser state not cleared after last byte");

    // a pending mid-line error means the parser sits in error mode
    a_err_mode: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.kind == cmdws_pkg::KIND_ERR && !out_ch.result_last
            |-> st_reg.mode == cmdws_pkg::MODE_ERROR)
        else $error("error result without error mode");

    // the last result of a line is the last one in the register
    a_last_final: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.result_last |-> cnt_reg - idx_reg == 2'd1)
        else $error("line end result not last in register");

endmodule

// ----- tb/cmdws_token_checker.sv -----
`timescale 1ns / 1ps
// cmdws_token_checker: watches both channels of the word splitter, predicts the
// result stream of every byte transfer and compares it with what comes out
// depends on cmdws_pkg, cmdws_in_if and cmdws_out_if
module cmdws_token_checker (
    input  logic clk,
    input  logic rst_n,
    cmdws_in_if  in_ch,
    cmdws_out_if out_ch,
    output int   fail_count,
    output int   pending
);

    // predicted parser state
    cmdws_pkg::mode_t  pmode;
    logic              sep_ok;
    logic              cr_wait;
    logic [15:0]       word_cnt;
    logic [1:0]        err_kept;

    // per-byte bookkeeping
    int                step_n;
    logic              err_now;
    int                mismatch_n;

    // results still to come, oldest first
    cmdws_pkg::result_t  pending_tokens[$];
    cmdws_pkg::result_t  got;
    cmdws_pkg::result_t  want;

    task automatic clear_parser();
        pmode    = cmdws_pkg::MODE_BETWEEN;
        sep_ok   = 1'b1;
        cr_wait  = 1'b0;
        word_cnt = 16'd0;
        err_kept = cmdws_pkg::ERR_BADCHAR;
    endtask

    task automatic push_result(input cmdws_pkg::kind_t k, input logic [7:0] v);
        pending_tokens.push_back('{kind: k, value: v, words: word_cnt, last: 1'b0});
        step_n++;
    endtask

    task automatic raise_error(input logic [1:0] code);
        pmode    = cmdws_pkg::MODE_ERROR;
        err_kept = code;
        err_now  = 1'b1;
        push_result(cmdws_pkg::KIND_ERR, {6'd0, code});
    endtask

    task automatic close_word(input logic sep_after);
        if (word_cnt != cmdws_pkg::TALLY_MAX)
            word_cnt = word_cnt + 16'd1;
        push_result(cmdws_pkg::KIND_EOW, 8'd0);
        pmode  = cmdws_pkg::MODE_BETWEEN;
        sep_ok = sep_after;
    endtask

    // one byte inside an unquoted word
    task automatic plain_char(input logic [7:0] c);
        if (c == cmdws_pkg::CH_SPACE || c == cmdws_pkg::CH_TAB)
            close_word(1'b1);
        else if (c == cmdws_pkg::CH_NUL || c == cmdws_pkg::CH_LF ||
                 c == cmdws_pkg::CH_CR || c == cmdws_pkg::CH_BSLASH ||
                 c == cmdws_pkg::CH_DQUOTE || c == cmdws_pkg::CH_SQUOTE)
            raise_error(cmdws_pkg::ERR_BADCHAR);
        else
            push_result(cmdws_pkg::KIND_BYTE, c);
    endtask

    // parse one byte once the held CR question is settled
    task automatic parse_byte(input logic [7:0] c);
        case (pmode)
            cmdws_pkg::MODE_BETWEEN:
            begin
                if (c == cmdws_pkg::CH_SPACE || c == cmdws_pkg::CH_TAB)
                    sep_ok = 1'b1;
                else if (!sep_ok)
                    raise_error(cmdws_pkg::ERR_NOSEP);
                else
                begin
                    sep_ok = 1'b0;
                    if (c == cmdws_pkg::CH_SQUOTE)
                        pmode = cmdws_pkg::MODE_SINGLE;
                    else if (c == cmdws_pkg::CH_DQUOTE)
                        pmode = cmdws_pkg::MODE_DOUBLE;
                    else
                    begin
                        pmode = cmdws_pkg::MODE_PLAIN;
                        plain_char(c);
                    end
                end
            end
            cmdws_pkg::MODE_PLAIN:
                plain_char(c);
            cmdws_pkg::MODE_SINGLE, cmdws_pkg::MODE_DOUBLE:
            begin
                if ((pmode == cmdws_pkg::MODE_SINGLE && c == cmdws_pkg::CH_SQUOTE) ||
                    (pmode == cmdws_pkg::MODE_DOUBLE && c == cmdws_pkg::CH_DQUOTE))
                    close_word(1'b0);
                else if (c == cmdws_pkg::CH_NUL || c == cmdws_pkg::CH_LF ||
                         c == cmdws_pkg::CH_CR)
                    raise_error(cmdws_pkg::ERR_BADCHAR);
                else if (pmode == cmdws_pkg::MODE_DOUBLE && c == cmdws_pkg::CH_BSLASH)
                    pmode = cmdws_pkg::MODE_ESCAPE;
                else
                    push_result(cmdws_pkg::KIND_BYTE, c);
            end
            cmdws_pkg::MODE_ESCAPE:
            begin
                if (c == cmdws_pkg::CH_LOW_N || c == cmdws_pkg::CH_LOW_R ||
                    c == cmdws_pkg::CH_LOW_T || c == cmdws_pkg::CH_BSLASH ||
                    c == cmdws_pkg::CH_DQUOTE)
                begin
                    pmode = cmdws_pkg::MODE_DOUBLE;
                    push_result(cmdws_pkg::KIND_BYTE,
                                (c == cmdws_pkg::CH_LOW_N) ? cmdws_pkg::CH_LF :
                                (c == cmdws_pkg::CH_LOW_R) ? cmdws_pkg::CH_CR :
                                (c == cmdws_pkg::CH_LOW_T) ? cmdws_pkg::CH_TAB : c);
                end
                else
                    raise_error(cmdws_pkg::ERR_BADESC);
            end
            default:
            begin
                // error mode stays silent until the final byte
            end
        endcase
    endtask

    // expected results of one accepted byte, with the trailing CR/LF rule
    task automatic predict_byte(input logic [7:0] c, input logic is_last);
        step_n  = 0;
        err_now = 1'b0;
        if (is_last)
        begin
            if (c != cmdws_pkg::CH_LF)
            begin
                if (cr_wait)
                    parse_byte(cmdws_pkg::CH_CR);
                if (c != cmdws_pkg::CH_CR)
                    parse_byte(c);
            end
            // close out the line
            case (pmode)
                cmdws_pkg::MODE_BETWEEN:
                    push_result(cmdws_pkg::KIND_DONE, 8'd0);
                cmdws_pkg::MODE_PLAIN:
                begin
                    close_word(1'b1);
                    push_result(cmdws_pkg::KIND_DONE, 8'd0);
                end
                cmdws_pkg::MODE_SINGLE, cmdws_pkg::MODE_DOUBLE:
                    raise_error(cmdws_pkg::ERR_UNCLOSE);
                cmdws_pkg::MODE_ESCAPE:
                    raise_error(cmdws_pkg::ERR_BADESC);
                default:
                begin
                    if (!(err_now && step_n > 0))
                        push_result(cmdws_pkg::KIND_ERR, {6'd0, err_kept});
                end
            endcase
            pending_tokens[$].last = 1'b1;
            clear_parser();
        end
        else
        begin
            if (cr_wait)
                parse_byte(cmdws_pkg::CH_CR);
            if (c == cmdws_pkg::CH_CR)
                cr_wait = 1'b1;
            else
            begin
                cr_wait = 1'b0;
                parse_byte(c);
            end
        end
    endtask

    // predict on byte transfers, compare on result transfers
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_parser();
            pending_tokens.delete();
            mismatch_n = 0;
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
                predict_byte(in_ch.char_in, in_ch.line_last);
            if (out_ch.valid && out_ch.ready)
            begin
                got = '{kind: cmdws_pkg::kind_t'(out_ch.kind), value: out_ch.value,
                        words: out_ch.words_seen, last: out_ch.result_last};
                if (pending_tokens.size() == 0)
                begin
                    mismatch_n++;
                    if (mismatch_n <= 10)
                        $display("%0t unexpected result: kind %0d value %h words %0d last %b",
                                 $time, got.kind, got.value, got.words, got.last);
                end
                else
                begin
                    want = pending_tokens.pop_front();
                    if (got.kind !== want.kind || got.value !== want.value ||
                        got.words !== want.words || got.last !== want.last)
                    begin
                        mismatch_n++;
                        if (mismatch_n <= 10)
                        begin
                            $display("%0t mismatch: expected kind %0d value %h words %0d last %b",
                                     $time, want.kind, want.value, want.words, want.last);
                            $display("%0t           actual kind %0d value %h words %0d last %b",
                                     $time, got.kind, got.value, got.words, got.last);
                        end
                    end
                end
            end
            fail_count <= mismatch_n;
            pending    <= pending_tokens.size();
        end
    end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// tb: stimulus and verdict for command_line_word_splitter_top, directed and
// random command lines; depends on cmdws_pkg, both channel interfaces and
// cmdws_token_checker
module tb;

    typedef enum int {
        W_PLAIN  = 0,
        W_SINGLE = 1,
        W_DOUBLE = 2
    } word_style_t;

    logic       clk;
    logic       rst_n;
    logic       calm = 1'b0;
    int         fail_count;
    int         pending;
    int         rand_bytes;
    int         line_n;
    int         wait_n;
    logic [7:0] line_q[$];

    cmdws_in_if  in_ch();
    cmdws_out_if out_ch();

    command_line_word_splitter_top u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    cmdws_token_checker u_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // overall time limit
    initial
    begin
        #200000;
        $display("== FAIL ==");
        $finish;
    end

    // result side back-pressure
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= calm || ($urandom_range(0, 99) >= 37);
    end

    // byte that a word of the given style may hold literally
    function automatic logic [7:0] pick_char(input word_style_t st);
        logic [7:0] c;
        logic       ok;
        do
        begin
            if ($urandom_range(0, 3) != 0)
                c = 8'($urandom_range(32, 126));
            else
                c = 8'($urandom_range(0, 255));
            case (st)
                W_PLAIN:
                    ok = !(c == cmdws_pkg::CH_SPACE || c == cmdws_pkg::CH_TAB ||
                           c == cmdws_pkg::CH_NUL || c == cmdws_pkg::CH_LF ||
                           c == cmdws_pkg::CH_CR || c == cmdws_pkg::CH_BSLASH ||
                           c == cmdws_pkg::CH_DQUOTE || c == cmdws_pkg::CH_SQUOTE);
                W_SINGLE:
                    ok = !(c == cmdws_pkg::CH_SQUOTE || c == cmdws_pkg::CH_NUL ||
                           c == cmdws_pkg::CH_LF || c == cmdws_pkg::CH_CR);
                default:
                    ok = !(c == cmdws_pkg::CH_DQUOTE || c == cmdws_pkg::CH_BSLASH ||
                           c == cmdws_pkg::CH_NUL || c == cmdws_pkg::CH_LF ||
                           c == cmdws_pkg::CH_CR);
            endcase
        end
        while (!ok);
        return c;
    endfunction

    // byte biased toward the characters the parser treats specially
    function automatic logic [7:0] noise_char();
        case ($urandom_range(0, 11))
            0:       return cmdws_pkg::CH_NUL;
            1:       return cmdws_pkg::CH_TAB;
            2:       return cmdws_pkg::CH_LF;
            3:       return cmdws_pkg::CH_CR;
            4:       return cmdws_pkg::CH_SPACE;
            5:       return cmdws_pkg::CH_DQUOTE;
            6:       return cmdws_pkg::CH_SQUOTE;
            7:       return cmdws_pkg::CH_BSLASH;
            8:       return cmdws_pkg::CH_LOW_N;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic add_blanks();
        repeat ($urandom_range(1, 2))
            line_q.push_back(($urandom_range(0, 1) != 0) ? cmdws_pkg::CH_SPACE :
                                                           cmdws_pkg::CH_TAB);
    endtask

    task automatic add_word(input word_style_t st);
        int n;
        if (st == W_PLAIN)
        begin
            repeat ($urandom_range(1, 6))
                line_q.push_back(pick_char(W_PLAIN));
        end
        else
        begin
            n = $urandom_range(0, 6);
            line_q.push_back((st == W_SINGLE) ? cmdws_pkg::CH_SQUOTE : cmdws_pkg::CH_DQUOTE);
            repeat (n)
            begin
                if (st == W_DOUBLE && $urandom_range(0, 3) == 0)
                begin
                    // escape sequence
                    line_q.push_back(cmdws_pkg::CH_BSLASH);
                    case ($urandom_range(0, 4))
                        0:       line_q.push_back(cmdws_pkg::CH_LOW_N);
                        1:       line_q.push_back(cmdws_pkg::CH_LOW_R);
                        2:       line_q.push_back(cmdws_pkg::CH_LOW_T);
                        3:       line_q.push_back(cmdws_pkg::CH_BSLASH);
                        default: line_q.push_back(cmdws_pkg::CH_DQUOTE);
                    endcase
                end
                else
                    line_q.push_back(pick_char(st));
            end
            line_q.push_back((st == W_SINGLE) ? cmdws_pkg::CH_SQUOTE : cmdws_pkg::CH_DQUOTE);
        end
    endtask

    // mostly well-formed lines, some corrupted, some pure noise
    task automatic make_line();
        int nw;
        int r;
        line_q.delete();
        r  = $urandom_range(0, 99);
        nw = $urandom_range(0, 5);
        if ($urandom_range(0, 3) == 0)
            add_blanks();
        for (int i = 0; i < nw; i++)
        begin
            if (i > 0 && $urandom_range(0, 9) != 0)
                add_blanks();
            add_word(word_style_t'($urandom_range(0, 2)));
        end
        if ($urandom_range(0, 2) == 0)
            add_blanks();
        // optional line terminator
        case ($urandom_range(0, 3))
            0:
                line_q.push_back(cmdws_pkg::CH_LF);
            1:
                line_q.push_back(cmdws_pkg::CH_CR);
            2:
            begin
                line_q.push_back(cmdws_pkg::CH_CR);
                line_q.push_back(cmdws_pkg::CH_LF);
            end
            default:
            begin
            end
        endcase
        if (r < 15 && line_q.size() > 0)
            line_q[$urandom_range(0, line_q.size() - 1)] = noise_char();
        else if (r < 25)
        begin
            line_q.delete();
            repeat ($urandom_range(1, 8))
                line_q.push_back(noise_char());
        end
        if (line_q.size() == 0)
            line_q.push_back(noise_char());
    endtask

    // one byte transfer, with random idle cycles ahead of it
    task automatic send_byte(input logic [7:0] c, input logic is_last);
        while (!calm && $urandom_range(0, 99) < 37)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.char_in   <= c;
        in_ch.line_last <= is_last;
        do
            @(posedge clk);
        while (!in_ch.ready);
    endtask

    task automatic send_line();
        for (int i = 0; i < line_q.size(); i++)
            send_byte(line_q[i], i == line_q.size() - 1);
    endtask

    // main stimulus
    initial
    begin
        rst_n           <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.char_in   <= 8'd0;
        in_ch.line_last <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // escape in double quotes, trailing CR-LF dropped
        line_q = '{cmdws_pkg::CH_DQUOTE, cmdws_pkg::CH_BSLASH, cmdws_pkg::CH_LOW_N,
                   cmdws_pkg::CH_DQUOTE, cmdws_pkg::CH_CR, cmdws_pkg::CH_LF};
        send_line();
        // empty quoted word, tab separator, trailing CR dropped
        line_q = '{cmdws_pkg::CH_SQUOTE, cmdws_pkg::CH_SQUOTE, cmdws_pkg::CH_SPACE,
                   cmdws_pkg::CH_TAB, "x", cmdws_pkg::CH_CR};
        send_line();
        // CR that is not trailing, then silence until the final byte
        line_q = '{"a", cmdws_pkg::CH_CR, "b"};
        send_line();
        // word right after a closed quoted word
        line_q = '{cmdws_pkg::CH_SQUOTE, "a", cmdws_pkg::CH_SQUOTE, "b"};
        send_line();
        // unknown escape letter
        line_q = '{cmdws_pkg::CH_DQUOTE, cmdws_pkg::CH_BSLASH, "q"};
        send_line();
        // line ends right after a backslash
        line_q = '{cmdws_pkg::CH_DQUOTE, cmdws_pkg::CH_BSLASH};
        send_line();
        // unclosed single quote
        line_q = '{cmdws_pkg::CH_SQUOTE, "x"};
        send_line();
        // byte extremes, error on the final byte
        line_q = '{8'hFF, cmdws_pkg::CH_NUL};
        send_line();
        // lone trailing LF
        line_q = '{cmdws_pkg::CH_LF};
        send_line();

        // random lines
        rand_bytes = 0;
        line_n     = 0;
        while (rand_bytes < 360)
        begin
            make_line();
            calm <= (line_n >= 8 && line_n < 14);
            send_line();
            rand_bytes += line_q.size();
            line_n++;
        end
        in_ch.valid <= 1'b0;

        // drain
        wait_n = 0;
        do
        begin
            @(posedge clk);
            wait_n++;
        end
        while (pending != 0 && wait_n < 20000);
        if (pending != 0)
        begin
            $display("== FAIL ==");
        end
        else
        begin
            repeat (20) @(posedge clk);
            if (fail_count == 0)
                $display("== PASS ==");
            else
                $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/cmdws_pkg.sv
rtl/cmdws_in_if.sv
rtl/cmdws_out_if.sv
rtl/cmdws_step.sv
rtl/command_line_word_splitter_top.sv
tb/cmdws_token_checker.sv
tb/tb.sv
